@@ rtl/core/ignition_boost_request_zone_unit_defines.svh @@
// Assertion macros shared by the checker of the boost request unit.
`ifndef IGNITION_BOOST_REQUEST_ZONE_UNIT_DEFINES_SVH
`define IGNITION_BOOST_REQUEST_ZONE_UNIT_DEFINES_SVH

// Condition that must hold at every edge outside reset.
`define IBRZ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Antecedent at one edge requires the consequent at the next edge.
`define IBRZ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Checked through reset as well.
`define IBRZ_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ibrz_pkg.sv @@
`default_nettype none
package ibrz_pkg;

  localparam int SPEED_POINTS = 9;
  localparam int LOAD_POINTS  = 8;
  localparam int SPEED_IDX_W  = (SPEED_POINTS > 1) ? $clog2(SPEED_POINTS) : 1;
  localparam int LOAD_IDX_W   = (LOAD_POINTS > 1) ? $clog2(LOAD_POINTS) : 1;

  localparam int TIX_W     = 4;
  localparam int TVAL_W    = 16;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_EVAL     = 2'd0,
    OP_SPEED_BP = 2'd1,
    OP_LOAD_BP  = 2'd2,
    OP_MAP_ROW  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATIO_LOW  = 3'd0,
    CFG_RATIO_HIGH = 3'd1,
    CFG_ADAPT_CODE = 3'd2,
    CFG_MIN_DIST   = 3'd3,
    CFG_ON_DELAY   = 3'd4,
    CFG_OFF_DELAY  = 3'd5,
    CFG_ENABLE     = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  ratio_low;
    logic [7:0]  ratio_high;
    logic [7:0]  adapt_code;
    logic [31:0] min_dist;
    logic [15:0] on_delay;
    logic [15:0] off_delay;
    logic        enable;
  } cfg_t;

  typedef struct packed {
    logic              speed_we;
    logic              load_we;
    logic              map_we;
    logic [TIX_W-1:0]  index;
    logic [TVAL_W-1:0] value;
  } tbl_wr_t;

  // Packed so that boost lands in bit 0.
  typedef struct packed {
    logic latched;
    logic opp;
    logic ratio;
    logic boost;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/core/ibrz_lookup.sv @@
`default_nettype none
module ibrz_lookup (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ibrz_pkg::tbl_wr_t wr,
  input  wire logic [15:0]     engine_speed,
  input  wire logic [15:0]     air_load,
  output logic                 zone_opportunity
);
  import ibrz_pkg::*;

  logic [15:0]            speed_bp_r [SPEED_POINTS];
  logic [15:0]            load_bp_r  [LOAD_POINTS];
  logic [LOAD_POINTS-1:0] map_r      [SPEED_POINTS];

  logic                   speed_ok;
  logic                   load_ok;
  logic [SPEED_IDX_W-1:0] wr_sidx;
  logic [LOAD_IDX_W-1:0]  wr_lidx;
  logic [SPEED_IDX_W-1:0] xi;
  logic [LOAD_IDX_W-1:0]  yi;
  logic [LOAD_POINTS-1:0] row;

  assign speed_ok = {1'b0, wr.index} < (TIX_W+1)'(SPEED_POINTS);
  assign load_ok  = {1'b0, wr.index} < (TIX_W+1)'(LOAD_POINTS);
  assign wr_sidx  = wr.index[SPEED_IDX_W-1:0];
  assign wr_lidx  = wr.index[LOAD_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SPEED_POINTS; i++) begin
        speed_bp_r[i] <= '0;
        map_r[i]      <= '0;
      end
      for (int j = 0; j < LOAD_POINTS; j++) begin
        load_bp_r[j] <= '0;
      end
    end else begin
      if (wr.speed_we && speed_ok) speed_bp_r[wr_sidx] <= wr.value;
      if (wr.load_we && load_ok)   load_bp_r[wr_lidx]  <= wr.value;
      if (wr.map_we && speed_ok)   map_r[wr_sidx]      <= wr.value[LOAD_POINTS-1:0];
    end
  end

  // Highest-indexed breakpoint not above the sample wins; zero when none qualifies.
  always_comb begin
    xi = '0;
    for (int i = 0; i < SPEED_POINTS; i++) begin
      if (speed_bp_r[i] <= engine_speed) xi = SPEED_IDX_W'(i);
    end
  end

  always_comb begin
    yi = '0;
    for (int j = 0; j < LOAD_POINTS; j++) begin
      if (load_bp_r[j] <= air_load) yi = LOAD_IDX_W'(j);
    end
  end

  assign row              = map_r[xi];
  assign zone_opportunity = row[yi];

endmodule
`default_nettype wire

@@ rtl/core/ibrz_eval.sv @@
`default_nettype none
module ibrz_eval (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           tick,
  input  wire ibrz_pkg::cfg_t cfg,
  input  wire logic [7:0]     energy_ratio,
  input  wire logic [7:0]     ignition_state,
  input  wire logic [31:0]    distance,
  input  wire logic           zone_opportunity,
  output ibrz_pkg::res_t      res
);
  import ibrz_pkg::*;

  logic        trig_r, trig_nxt;
  logic        prev_r;
  logic [15:0] on_cnt_r, on_cnt_nxt;
  logic [15:0] off_cnt_r, off_cnt_nxt;
  logic        latch_r, latch_nxt;
  logic        cond;
  logic        ratio_req;
  logic        set_req;
  logic        release_req;

  always_comb begin
    trig_nxt = trig_r;
    if (energy_ratio <= cfg.ratio_low) begin
      trig_nxt = 1'b1;
    end else if (energy_ratio >= cfg.ratio_high) begin
      trig_nxt = 1'b0;
    end
  end

  assign ratio_req = trig_nxt && (ignition_state == cfg.adapt_code);
  assign cond      = zone_opportunity && (distance >= cfg.min_dist);

  always_comb begin
    on_cnt_nxt  = on_cnt_r;
    off_cnt_nxt = off_cnt_r;
    set_req     = 1'b0;
    release_req = 1'b0;
    if (cond) begin
      // Reload on the first tick of the condition, then count down.
      if (!prev_r) begin
        on_cnt_nxt = cfg.on_delay;
      end else if (on_cnt_r != '0) begin
        on_cnt_nxt = on_cnt_r - 16'd1;
      end
      set_req = (on_cnt_nxt == '0);
    end else begin
      if (prev_r) begin
        off_cnt_nxt = cfg.off_delay;
      end else if (off_cnt_r != '0) begin
        off_cnt_nxt = off_cnt_r - 16'd1;
      end
      release_req = (off_cnt_nxt == '0);
    end
  end

  always_comb begin
    latch_nxt = latch_r;
    if (release_req) begin
      latch_nxt = 1'b0;
    end else if (set_req) begin
      latch_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r    <= 1'b0;
      prev_r    <= 1'b0;
      on_cnt_r  <= '0;
      off_cnt_r <= '0;
      latch_r   <= 1'b0;
    end else if (tick) begin
      trig_r    <= trig_nxt;
      prev_r    <= cond;
      on_cnt_r  <= on_cnt_nxt;
      off_cnt_r <= off_cnt_nxt;
      latch_r   <= latch_nxt;
    end
  end

  assign res.latched = latch_nxt;
  assign res.opp     = zone_opportunity;
  assign res.ratio   = ratio_req;
  assign res.boost   = (ratio_req || latch_nxt) && cfg.enable;

endmodule
`default_nettype wire

@@ rtl/core/ignition_boost_request_zone_unit.sv @@
// Ignition boost request unit. Each word on the input stream is either an
// evaluate tick (tuser = 0) or a write into the speed breakpoint, load
// breakpoint or zone map table (tuser = 1, 2, 3); only ticks return a result
// word. One word is taken per clock: a word lands in the input register, the
// whole tick is evaluated by one pass of logic (parallel breakpoint compares,
// map select, delay counters) and written to the result register. Throughput
// drops only while the result register is held by out_tready low. The tables
// are cleared by reset; configuration registers are to be written through the
// cfg port only while the stream is idle, which the block does not enforce.
`default_nettype none
module ignition_boost_request_zone_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // table_index, table_value, energy_ratio, ignition_state, engine_speed,
  // air_load, distance, zero fill
  input  wire logic [ibrz_pkg::IN_DATA_W-1:0]     in_tdata,
  // operation
  input  wire logic [1:0]                         in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // boost_request, ratio_request, zone_opportunity, zone_latched, zero fill
  output logic [ibrz_pkg::OUT_DATA_W-1:0]         out_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [ibrz_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ibrz_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ibrz_pkg::*;

  cfg_t        cfg_r;

  logic        s1_valid_r;
  op_t         s1_op_r;
  logic [3:0]  s1_tix_r;
  logic [15:0] s1_tval_r;
  logic [7:0]  s1_ratio_r;
  logic [7:0]  s1_ign_r;
  logic [15:0] s1_speed_r;
  logic [15:0] s1_load_r;
  logic [31:0] s1_dist_r;

  logic        out_valid_r;
  res_t        out_res_r;

  logic        out_free;
  logic        fire;
  logic        tick;
  logic        in_take;
  tbl_wr_t     tbl_wr;
  logic        zone_opp;
  res_t        res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ratio_low  <= '0;
      cfg_r.ratio_high <= 8'hFF;
      cfg_r.adapt_code <= '0;
      cfg_r.min_dist   <= '0;
      cfg_r.on_delay   <= '0;
      cfg_r.off_delay  <= '0;
      cfg_r.enable     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RATIO_LOW:  cfg_r.ratio_low  <= cfg_wdata[7:0];
        CFG_RATIO_HIGH: cfg_r.ratio_high <= cfg_wdata[7:0];
        CFG_ADAPT_CODE: cfg_r.adapt_code <= cfg_wdata[7:0];
        CFG_MIN_DIST:   cfg_r.min_dist   <= cfg_wdata;
        CFG_ON_DELAY:   cfg_r.on_delay   <= cfg_wdata[15:0];
        CFG_OFF_DELAY:  cfg_r.off_delay  <= cfg_wdata[15:0];
        CFG_ENABLE:     cfg_r.enable     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // A write word needs no result slot; a tick waits for a free one.
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && ((s1_op_r != OP_EVAL) || out_free);
  assign tick      = fire && (s1_op_r == OP_EVAL);
  assign in_tready = !s1_valid_r || fire;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r    <= op_t'(in_tuser);
      s1_tix_r   <= in_tdata[3:0];
      s1_tval_r  <= in_tdata[19:4];
      s1_ratio_r <= in_tdata[27:20];
      s1_ign_r   <= in_tdata[35:28];
      s1_speed_r <= in_tdata[51:36];
      s1_load_r  <= in_tdata[67:52];
      s1_dist_r  <= in_tdata[99:68];
    end
  end

  always_comb begin
    tbl_wr.speed_we = fire && (s1_op_r == OP_SPEED_BP);
    tbl_wr.load_we  = fire && (s1_op_r == OP_LOAD_BP);
    tbl_wr.map_we   = fire && (s1_op_r == OP_MAP_ROW);
    tbl_wr.index    = s1_tix_r;
    tbl_wr.value    = s1_tval_r;
  end

  ibrz_lookup u_lookup (
    .clk              (clk),
    .rst_n            (rst_n),
    .wr               (tbl_wr),
    .engine_speed     (s1_speed_r),
    .air_load         (s1_load_r),
    .zone_opportunity (zone_opp)
  );

  ibrz_eval u_eval (
    .clk              (clk),
    .rst_n            (rst_n),
    .tick             (tick),
    .cfg              (cfg_r),
    .energy_ratio     (s1_ratio_r),
    .ignition_state   (s1_ign_r),
    .distance         (s1_dist_r),
    .zone_opportunity (zone_opp),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W-4)'(0), out_res_r};

endmodule
`default_nettype wire

@@ rtl/core/ibrz_checker.sv @@
`default_nettype none
`include "ignition_boost_request_zone_unit_defines.svh"
module ibrz_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [ibrz_pkg::OUT_DATA_W-1:0] out_tdata
);

  // Boost comes only from the ratio path or the zone latch.
  `IBRZ_ASSERT_ALWAYS(a_boost_source, !out_tvalid || !out_tdata[0] || out_tdata[1] || out_tdata[3], "boost without a source")

  // Spare result bits stay zero.
  `IBRZ_ASSERT_ALWAYS(a_out_fill, !out_tvalid || (out_tdata[7:4] == 4'd0), "result fill bits set")

  // A held result stays put.
  `IBRZ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // Reset empties the result side.
  `IBRZ_ASSERT_RESET(a_reset_empty, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind ignition_boost_request_zone_unit ibrz_checker u_ibrz_checker (.*);
`default_nettype wire
